// ===== rtl/pwlti_pkg.sv =====
// shared constants, codes and types of the piecewise linear table interpolator
`timescale 1ns / 1ps
`default_nettype none

package pwlti_pkg;

    localparam int ACT_W   = 2;
    localparam int IDX_W   = 10;
    localparam int TIME_W  = 32;
    localparam int VAL_W   = 32;
    localparam int PROD_W  = 64;
    localparam int DIV_STEPS = PROD_W;
    localparam int DEFAULT_MAX_POINTS = 1024;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UB,
        S_CHK0,
        S_DOWN,
        S_UP,
        S_LO,
        S_MUL,
        S_DIV,
        S_RND,
        S_PUT
    } state_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quo;
        logic [TIME_W-1:0] rem;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pwlti_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface pwlti_req_if;
    import pwlti_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         index;
    logic [TIME_W-1:0]        time_req;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, action, index, time_req, value, input ready);
    modport sink   (input valid, action, index, time_req, value, output ready);
endinterface

interface pwlti_res_if;
    import pwlti_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  result_value;
    logic [IDX_W-1:0]         segment_end;

    modport source (output valid, result_value, segment_end, input ready);
    modport sink   (input valid, result_value, segment_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/pwlti_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pwlti_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [pwlti_pkg::PROD_W-1:0]   dividend,
    input  wire logic [pwlti_pkg::TIME_W-1:0]   divisor,
    output pwlti_pkg::div_stat_t                stat
);
    import pwlti_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [TIME_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? TIME_W'(trial - {1'b0, dvs_reg}) : trial[TIME_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done = done_reg;
    assign stat.quo  = quo_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_table_interp.sv =====
// top level: breakpoint table, search sequencer and interpolation datapath
//
//  port          dir   handshake          carries
//  req           in    valid / ready      action, index, time_req, value
//  res           out   valid / ready      result_value, segment_end
//  cfg_wr_en     in    write enable       cfg_wr_data -> upper_index
//
//  write and restart requests do not leave the idle state, so ready stays high
//  a query walks the breakpoints one by one and then runs the serial divider;
//  the table ram gives one entry a cycle
//  a query at or before the first breakpoint time or at upper index zero skips the divider
//  rst_n clears the search position, upper_index, the sequencer and the result valid; no table clear
//  a finished result waits in the output register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interp #(
    parameter int MAX_POINTS = pwlti_pkg::DEFAULT_MAX_POINTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    pwlti_req_if.sink                        req,
    pwlti_res_if.source                      res,
    input  wire logic                        cfg_wr_en,
    input  wire logic [pwlti_pkg::IDX_W-1:0] cfg_wr_data
);
    import pwlti_pkg::*;

    localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int ENT_W = TIME_W + VAL_W;
    localparam logic [PW-1:0] LAST = PW'(MAX_POINTS - 1);

    // table ram
    logic [ENT_W-1:0] mem [MAX_POINTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [PW-1:0]    rd_addr;
    logic             mem_we;
    logic [PW-1:0]    wr_addr;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]        ub_reg, ub_next;
    logic [PW-1:0]           sp_reg, sp_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [TIME_W-1:0]       q_reg, q_next;
    logic [TIME_W-1:0]       t1_reg, t1_next;
    logic signed [VAL_W-1:0] x1_reg, x1_next;
    logic signed [VAL_W-1:0] x0_reg, x0_next;
    logic [TIME_W-1:0]       an_reg, an_next;
    logic [TIME_W-1:0]       ad_reg, ad_next;
    logic [TIME_W-1:0]       ax_reg, ax_next;
    logic                    neg_reg, neg_next;
    logic [PROD_W-1:0]       quo_reg, quo_next;
    logic signed [VAL_W-1:0] rv_reg, rv_next;
    logic [IDX_W-1:0]        seg_reg, seg_next;
    logic                    ov_reg, ov_next;
    logic signed [VAL_W-1:0] oval_reg, oval_next;
    logic [IDX_W-1:0]        oseg_reg, oseg_next;

    logic                    req_fire;
    logic [PW-1:0]           ub_c;
    logic [TIME_W-1:0]       rd_t;
    logic signed [VAL_W-1:0] rd_x;
    logic                    q_ge;
    logic                    walk_dn, walk_up;

    logic signed [TIME_W:0]  num, den, dx;
    logic signed [VAL_W:0]   hsum;
    logic signed [VAL_W:0]   half;
    logic                    round_up;
    logic signed [VAL_W+4:0] x0e, dmag, sum;
    logic                    big;

    logic                    div_start;
    div_stat_t               div_stat;

    pwlti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (an_reg * ax_reg),
        .divisor  (ad_reg),
        .stat     (div_stat)
    );

    assign req_fire = req.valid && req.ready;
    assign ub_c     = (32'(ub_reg) < MAX_POINTS) ? PW'(ub_reg) : LAST;
    assign rd_t     = rd_data_reg[ENT_W-1:VAL_W];
    assign rd_x     = rd_data_reg[VAL_W-1:0];
    assign q_ge     = q_reg >= rd_t;
    assign walk_dn  = (pos_reg != '0) && !q_ge;
    assign walk_up  = (pos_reg != LAST) && q_ge;

    assign mem_we   = req_fire && (req.action == ACT_WRITE) && (32'(req.index) < MAX_POINTS);
    assign wr_addr  = PW'(req.index);

    // segment arithmetic on the lower breakpoint
    assign num  = $signed({1'b0, q_reg})  - $signed({1'b0, rd_t});
    assign den  = $signed({1'b0, t1_reg}) - $signed({1'b0, rd_t});
    assign dx   = $signed({x1_reg[VAL_W-1], x1_reg}) - $signed({rd_x[VAL_W-1], rd_x});
    assign hsum = $signed({x1_reg[VAL_W-1], x1_reg}) + $signed({rd_x[VAL_W-1], rd_x});
    assign half = (hsum + $signed({{VAL_W{1'b0}}, ~hsum[VAL_W]})) >>> 1;

    // rounding and final sum
    assign round_up = {div_stat.rem, 1'b0} >= {1'b0, ad_reg};
    assign big  = quo_reg > (PROD_W'(1) << 34);
    assign x0e  = {{5{x0_reg[VAL_W-1]}}, x0_reg};
    assign dmag = $signed({2'b00, quo_reg[34:0]});
    assign sum  = neg_reg ? (x0e - dmag) : (x0e + dmag);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_fire && req.action == ACT_QUERY)
                    state_next = S_UB;
            S_UB:
                if (q_ge)
                    state_next = (ub_c == '0) ? S_PUT : S_LO;
                else
                    state_next = S_CHK0;
            S_CHK0:
                state_next = (q_reg <= rd_t) ? S_PUT : S_DOWN;
            S_DOWN:
                if (walk_dn)
                    state_next = S_DOWN;
                else if (walk_up)
                    state_next = S_UP;
                else
                    state_next = S_LO;
            S_UP:
                if (!walk_up)
                    state_next = S_LO;
            S_LO:
                state_next = (rd_t == t1_reg) ? S_PUT : S_MUL;
            S_MUL:
                state_next = S_DIV;
            S_DIV:
                if (div_stat.done)
                    state_next = S_RND;
            S_RND:
                state_next = S_PUT;
            S_PUT:
                if (!ov_reg || res.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rd_addr   = ub_c;
        div_start = 1'b0;
        ub_next   = cfg_wr_en ? cfg_wr_data : ub_reg;
        sp_next   = sp_reg;
        pos_next  = pos_reg;
        q_next    = q_reg;
        t1_next   = t1_reg;
        x1_next   = x1_reg;
        x0_next   = x0_reg;
        an_next   = an_reg;
        ad_next   = ad_reg;
        ax_next   = ax_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rv_next   = rv_reg;
        seg_next  = seg_reg;
        ov_next   = (ov_reg && res.ready) ? 1'b0 : ov_reg;
        oval_next = oval_reg;
        oseg_next = oseg_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    q_next = req.time_req;
                    if (req.action == ACT_RESTART)
                        sp_next = '0;
                end
            end
            S_UB:
            begin
                if (q_ge)
                begin
                    sp_next  = ub_c;
                    pos_next = ub_c;
                    t1_next  = rd_t;
                    x1_next  = rd_x;
                    rv_next  = rd_x;
                    seg_next = '0;
                    rd_addr  = ub_c - 1'b1;
                end
                else
                begin
                    rd_addr = '0;
                end
            end
            S_CHK0:
            begin
                rv_next  = rd_x;
                seg_next = '0;
                rd_addr  = sp_reg;
                pos_next = sp_reg;
                if (q_reg <= rd_t)
                    sp_next = '0;
            end
            S_DOWN, S_UP:
            begin
                if (walk_dn && state_reg == S_DOWN)
                begin
                    pos_next = pos_reg - 1'b1;
                    rd_addr  = pos_reg - 1'b1;
                end
                else if (walk_up)
                begin
                    pos_next = pos_reg + 1'b1;
                    rd_addr  = pos_reg + 1'b1;
                end
                else
                begin
                    sp_next = pos_reg;
                    t1_next = rd_t;
                    x1_next = rd_x;
                    rd_addr = pos_reg - 1'b1;
                end
            end
            S_LO:
            begin
                x0_next  = rd_x;
                seg_next = IDX_W'(pos_reg);
                rv_next  = half[VAL_W-1:0];
                an_next  = num[TIME_W] ? TIME_W'(-num) : num[TIME_W-1:0];
                ad_next  = den[TIME_W] ? TIME_W'(-den) : den[TIME_W-1:0];
                ax_next  = dx[VAL_W]   ? TIME_W'(-dx)  : dx[VAL_W-1:0];
                neg_next = num[TIME_W] ^ den[TIME_W] ^ dx[VAL_W];
            end
            S_MUL:
            begin
                div_start = 1'b1;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    quo_next = div_stat.quo + PROD_W'(round_up);
            end
            S_RND:
            begin
                if (big)
                    rv_next = neg_reg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
                else if (sum[VAL_W+4:VAL_W-1] != {6{sum[VAL_W+4]}})
                    rv_next = sum[VAL_W+4] ? {1'b1, {(VAL_W-1){1'b0}}}
                                           : {1'b0, {(VAL_W-1){1'b1}}};
                else
                    rv_next = sum[VAL_W-1:0];
            end
            S_PUT:
            begin
                if (!ov_reg || res.ready)
                begin
                    ov_next   = 1'b1;
                    oval_next = rv_reg;
                    oseg_next = seg_reg;
                end
            end
            default:
            begin
                rd_addr = ub_c;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= {req.time_req, req.value};
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ub_reg    <= '0;
            sp_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ub_reg    <= ub_next;
            sp_reg    <= sp_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        q_reg    <= q_next;
        t1_reg   <= t1_next;
        x1_reg   <= x1_next;
        x0_reg   <= x0_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        ax_reg   <= ax_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rv_reg   <= rv_next;
        seg_reg  <= seg_next;
        oval_reg <= oval_next;
        oseg_reg <= oseg_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign res.valid        = ov_reg;
    assign res.result_value = oval_reg;
    assign res.segment_end  = oseg_reg;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> ad_reg != '0)
        else $error("divider started with zero divisor");

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= LAST)
        else $error("search position beyond table");

    a_seg_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LO |-> pos_reg != '0)
        else $error("segment end at entry zero");

    a_res_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == S_PUT))
        else $error("result loaded outside put state");

endmodule

`default_nettype wire
